/* rtl/core/kabf_pkg.sv */
// Shared types, constants and saturation helpers for the angle/bias Kalman filter.
`default_nettype none

package kabf_pkg;

  localparam int FRAC_BITS_DEF = 20;

  // Exact-sum width for the widest add chain (four 32-bit terms).
  localparam int ACC_W = 35;

  typedef struct packed {
    logic                    mul_en;
    logic signed [31:0]      mul_a;
    logic signed [31:0]      mul_b;
    logic signed [ACC_W-1:0] add_a;
    logic signed [ACC_W-1:0] add_b;
  } kabf_alu_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > 65'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -65'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] ext_acc(input logic signed [31:0] v);
    return {{(ACC_W-32){v[31]}}, v};
  endfunction

endpackage

`default_nettype wire

/* rtl/core/kabf_alu.sv */
// Shared arithmetic unit: registered 32x32 multiplier with Q rounding, exact adder.
`default_nettype none

module kabf_alu import kabf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire kabf_alu_req_t           req,
  output logic signed [31:0]           mul_res,
  output logic signed [ACC_W-1:0]      add_sum,
  output logic signed [31:0]           add_sat
);

  logic signed [63:0] prod;
  logic signed [64:0] rnd;
  logic signed [64:0] shifted;

  always_ff @(posedge clk) begin
    if (req.mul_en) begin
      prod <= req.mul_a * req.mul_b;
    end
  end

  // round half up, floor shift, clamp
  always_comb begin
    rnd     = {prod[63], prod} + (65'sd1 <<< (FRAC_BITS - 1));
    shifted = rnd >>> FRAC_BITS;
    mul_res = sat32(shifted);
  end

  assign add_sum = req.add_a + req.add_b;
  assign add_sat = sat32(65'(add_sum));

endmodule

`default_nettype wire

/* rtl/core/kabf_div.sv */
// Serial restoring divider for the Kalman gain: (num << FRAC_BITS) / den, saturated.
`default_nettype none

module kabf_div import kabf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  output logic                    done,
  output logic signed [31:0]      quot
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

  dstate_t          dstate;
  logic [CW-1:0]    cnt;
  logic [NW-1:0]    dvd;
  logic [32:0]      rem;
  logic [31:0]      dmag;
  logic             neg;
  logic             dzero;
  logic [32:0]      shl;
  logic [32:0]      trial;

  assign shl   = {rem[31:0], dvd[NW-1]};
  assign trial = shl - {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
    end else begin
      case (dstate)
        D_IDLE: begin
          if (start) begin
            dvd    <= {(num[31] ? 32'(-num) : 32'(num)), {FRAC_BITS{1'b0}}};
            dmag   <= den[31] ? 32'(-den) : 32'(den);
            rem    <= '0;
            neg    <= num[31] ^ den[31];
            dzero  <= (den == 32'sd0);
            cnt    <= CW'(NW);
            dstate <= D_RUN;
          end
        end
        D_RUN: begin
          if (!trial[32]) begin
            rem <= trial;
          end else begin
            rem <= shl;
          end
          dvd <= {dvd[NW-2:0], ~trial[32]};
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            dstate <= D_FIN;
          end
        end
        D_FIN:   dstate <= D_IDLE;
        default: dstate <= D_IDLE;
      endcase
    end
  end

  assign done = (dstate == D_FIN);

  always_comb begin
    if (dzero) begin
      quot = '0;
    end else if (neg) begin
      if ((|dvd[NW-1:32]) || (dvd[31] && (|dvd[30:0]))) begin
        quot = 32'sh80000000;
      end else begin
        quot = -$signed(dvd[31:0]);
      end
    end else begin
      if (|dvd[NW-1:31]) begin
        quot = 32'sh7fffffff;
      end else begin
        quot = $signed(dvd[31:0]);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/kalman_angle_bias_filter.sv */
// Two-state angle/bias Kalman filter top level: sequencer over shared ALU and divider.
//
// Input channel: in_valid/in_ready carry one beat of measured_angle and
// measured_rate (signed Q with FRAC_BITS fraction bits). Output channel:
// out_valid/out_ready carry one beat of filtered_angle per input beat.
// Config: cfg_we writes cfg_data into register cfg_index (0 sample_period,
// 1 angle_noise, 2 bias_noise, 3 measure_noise); write only while idle.
// One item at a time: in_ready is high only while the sequencer idles.
// An update runs the sequencer from accept to result; the two gain
// divisions each wait on the serial divider, one quotient bit per
// cycle, and the rest is one step per cycle through the single
// multiplier and adder. in_ready returns at the same edge that loads
// the result into the output register.
// The result sits in an output register; the next item may be accepted
// while it waits. If the receiver stalls, a finished update holds in its
// last step until the output register frees up.
// Reset (synchronous, active high) zeroes the estimate, bias and
// covariance and loads the default noise/period settings.
`default_nettype none

module kalman_angle_bias_filter import kabf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] measured_angle,
  input  wire logic signed [31:0] measured_rate,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      filtered_angle,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [30:0]        cfg_data
);

  // register indexes
  localparam logic [1:0] REG_DT = 2'd0;
  localparam logic [1:0] REG_QA = 2'd1;
  localparam logic [1:0] REG_QB = 2'd2;
  localparam logic [1:0] REG_R  = 2'd3;

  // reset defaults: round(c * 2^FRAC_BITS)
  localparam logic [30:0] DT_RST = 31'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [30:0] QA_RST = 31'(((64'd5 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [30:0] QB_RST = 31'(((64'd3 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [30:0] R_RST  = 31'(((64'd30 << FRAC_BITS) + 64'd500) / 64'd1000);

  typedef enum logic [4:0] {
    ST_IDLE, ST_RATE, ST_DTP, ST_ANG, ST_BR1, ST_BR2, ST_MBR, ST_AA, ST_BA,
    ST_BB, ST_S, ST_K0_GO, ST_K0_WAIT, ST_K1_GO, ST_K1_WAIT, ST_MK0, ST_ANG2,
    ST_BIAS, ST_CBA, ST_CBB, ST_CAB, ST_CAA, ST_DONE
  } state_t;

  state_t state;

  // config
  logic [30:0] dt_cfg, qa_cfg, qb_cfg, r_cfg;
  logic signed [31:0] dt, qa, qb, rn;

  // filter state
  logic signed [31:0] ang, bias, p_aa, p_ab, p_ba, p_bb;
  // per-item scratch
  logic signed [31:0] ma, mr, t_rate, t_dtp, t_br, t_s, t_inn, t_k0, t_k1;
  logic signed [ACC_W-1:0] acc;

  kabf_alu_req_t           req;
  logic signed [31:0]      mres;
  logic signed [ACC_W-1:0] add_sum;
  logic signed [31:0]      add_sat;

  logic               div_start;
  logic signed [31:0] div_num;
  logic               div_done;
  logic signed [31:0] div_quot;

  assign dt = $signed({1'b0, dt_cfg});
  assign qa = $signed({1'b0, qa_cfg});
  assign qb = $signed({1'b0, qb_cfg});
  assign rn = $signed({1'b0, r_cfg});

  assign in_ready = (state == ST_IDLE);

  kabf_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk     (clk),
    .req     (req),
    .mul_res (mres),
    .add_sum (add_sum),
    .add_sat (add_sat)
  );

  kabf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (t_s),
    .done  (div_done),
    .quot  (div_quot)
  );

  // operand select for the shared unit; mul result shows up one state later
  always_comb begin
    req       = '0;
    div_start = 1'b0;
    div_num   = p_aa;
    case (state)
      ST_RATE: begin
        req.add_a  = ext_acc(mr);
        req.add_b  = -ext_acc(bias);
        req.mul_en = 1'b1;
        req.mul_a  = dt;
        req.mul_b  = p_bb;
      end
      ST_DTP: begin
        req.add_a  = ext_acc(mres);
        req.add_b  = -ext_acc(p_ba);
        req.mul_en = 1'b1;
        req.mul_a  = dt;
        req.mul_b  = t_rate;
      end
      ST_ANG: begin
        req.add_a = ext_acc(ang);
        req.add_b = ext_acc(mres);
      end
      ST_BR1: begin
        req.add_a = acc;
        req.add_b = -ext_acc(p_ab);
      end
      ST_BR2: begin
        req.add_a = acc;
        req.add_b = ext_acc(qa);
      end
      ST_MBR: begin
        req.add_a  = ext_acc(p_ab);
        req.add_b  = -ext_acc(t_dtp);
        req.mul_en = 1'b1;
        req.mul_a  = dt;
        req.mul_b  = t_br;
      end
      ST_AA: begin
        req.add_a  = ext_acc(p_aa);
        req.add_b  = ext_acc(mres);
        req.mul_en = 1'b1;
        req.mul_a  = qb;
        req.mul_b  = dt;
      end
      ST_BA: begin
        req.add_a = ext_acc(p_ba);
        req.add_b = -ext_acc(t_dtp);
      end
      ST_BB: begin
        req.add_a = ext_acc(p_bb);
        req.add_b = ext_acc(mres);
      end
      ST_S: begin
        req.add_a = ext_acc(p_aa);
        req.add_b = ext_acc(rn);
      end
      ST_K0_GO: begin
        div_start = 1'b1;
        div_num   = p_aa;
        req.add_a = ext_acc(ma);
        req.add_b = -ext_acc(ang);
      end
      ST_K1_GO: begin
        div_start = 1'b1;
        div_num   = p_ba;
      end
      ST_MK0: begin
        req.mul_en = 1'b1;
        req.mul_a  = t_k0;
        req.mul_b  = t_inn;
      end
      ST_ANG2: begin
        req.add_a  = ext_acc(ang);
        req.add_b  = ext_acc(mres);
        req.mul_en = 1'b1;
        req.mul_a  = t_k1;
        req.mul_b  = t_inn;
      end
      ST_BIAS: begin
        req.add_a  = ext_acc(bias);
        req.add_b  = ext_acc(mres);
        req.mul_en = 1'b1;
        req.mul_a  = t_k1;
        req.mul_b  = p_aa;
      end
      // p_aa/p_ab stay at their predicted values until the last two steps
      ST_CBA: begin
        req.add_a  = ext_acc(p_ba);
        req.add_b  = -ext_acc(mres);
        req.mul_en = 1'b1;
        req.mul_a  = t_k1;
        req.mul_b  = p_ab;
      end
      ST_CBB: begin
        req.add_a  = ext_acc(p_bb);
        req.add_b  = -ext_acc(mres);
        req.mul_en = 1'b1;
        req.mul_a  = t_k0;
        req.mul_b  = p_ab;
      end
      ST_CAB: begin
        req.add_a  = ext_acc(p_ab);
        req.add_b  = -ext_acc(mres);
        req.mul_en = 1'b1;
        req.mul_a  = t_k0;
        req.mul_b  = p_aa;
      end
      ST_CAA: begin
        req.add_a = ext_acc(p_aa);
        req.add_b = -ext_acc(mres);
      end
      default: begin
        req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      dt_cfg    <= DT_RST;
      qa_cfg    <= QA_RST;
      qb_cfg    <= QB_RST;
      r_cfg     <= R_RST;
      ang       <= '0;
      bias      <= '0;
      p_aa      <= '0;
      p_ab      <= '0;
      p_ba      <= '0;
      p_bb      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DT:  dt_cfg <= cfg_data;
          REG_QA:  qa_cfg <= cfg_data;
          REG_QB:  qb_cfg <= cfg_data;
          REG_R:   r_cfg  <= cfg_data;
          default: dt_cfg <= dt_cfg;
        endcase
      end

      // ST_DONE reloads the output register itself
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            ma    <= measured_angle;
            mr    <= measured_rate;
            state <= ST_RATE;
          end
        end
        ST_RATE: begin
          t_rate <= add_sat;
          state  <= ST_DTP;
        end
        ST_DTP: begin
          t_dtp <= mres;
          acc   <= add_sum;
          state <= ST_ANG;
        end
        ST_ANG: begin
          ang   <= add_sat;
          state <= ST_BR1;
        end
        ST_BR1: begin
          acc   <= add_sum;
          state <= ST_BR2;
        end
        ST_BR2: begin
          t_br  <= add_sat;
          state <= ST_MBR;
        end
        ST_MBR: begin
          p_ab  <= add_sat;
          state <= ST_AA;
        end
        ST_AA: begin
          p_aa  <= add_sat;
          state <= ST_BA;
        end
        ST_BA: begin
          p_ba  <= add_sat;
          state <= ST_BB;
        end
        ST_BB: begin
          p_bb  <= add_sat;
          state <= ST_S;
        end
        ST_S: begin
          t_s   <= add_sat;
          state <= ST_K0_GO;
        end
        ST_K0_GO: begin
          t_inn <= add_sat;
          state <= ST_K0_WAIT;
        end
        ST_K0_WAIT: begin
          if (div_done) begin
            t_k0  <= div_quot;
            state <= ST_K1_GO;
          end
        end
        ST_K1_GO: state <= ST_K1_WAIT;
        ST_K1_WAIT: begin
          if (div_done) begin
            t_k1  <= div_quot;
            state <= ST_MK0;
          end
        end
        ST_MK0: state <= ST_ANG2;
        ST_ANG2: begin
          ang   <= add_sat;
          state <= ST_BIAS;
        end
        ST_BIAS: begin
          bias  <= add_sat;
          state <= ST_CBA;
        end
        ST_CBA: begin
          p_ba  <= add_sat;
          state <= ST_CBB;
        end
        ST_CBB: begin
          p_bb  <= add_sat;
          state <= ST_CAB;
        end
        ST_CAB: begin
          p_ab  <= add_sat;
          state <= ST_CAA;
        end
        ST_CAA: begin
          p_aa  <= add_sat;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            filtered_angle <= ang;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a beat but still ready");

  a_div_done_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_K0_WAIT || state == ST_K1_WAIT))
    else $error("divider finished outside a gain wait");

  a_done_emits: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && !out_valid |=> out_valid && state == ST_IDLE)
    else $error("finished update not delivered to output register");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("output beat without a finished update");
`endif

endmodule

`default_nettype wire
